// ----- src/weddle_rule_integrator_top_assert.svh -----
// assertion macros for the weddle rule integrator
// used inside modules that have clk and arst_n in scope
`ifndef WEDDLE_RULE_INTEGRATOR_TOP_ASSERT_SVH
`define WEDDLE_RULE_INTEGRATOR_TOP_ASSERT_SVH

// same-cycle implication
`define WRD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("weddle integrator check failed");

// next-cycle implication
`define WRD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("weddle integrator check failed");

`endif

// ----- src/wrd_pkg.sv -----
// shared types, constants and the panel weight function
// no dependencies
`default_nettype none
package wrd_pkg;
	localparam int DIV_W = 64;
	localparam int IT_W  = 7;
	localparam int MUL_W = 32;

	typedef struct packed {
		logic            start;
		logic [IT_W-1:0] iters;
	} div_req_t;

	// weight inside a panel, phase 0 is a shared panel end
	function automatic logic [2:0] wrd_weight(input logic [2:0] ph);
		logic [2:0] w;
		unique case (ph)
			3'd0: w = 3'd2;
			3'd1: w = 3'd5;
			3'd2: w = 3'd1;
			3'd3: w = 3'd6;
			3'd4: w = 3'd1;
			3'd5: w = 3'd5;
			default: w = 3'd0;
		endcase
		return w;
	endfunction
endpackage
`default_nettype wire

// ----- src/wrd_in_if.sv -----
// input channel: integration limits and panel count
// no dependencies
`default_nettype none
interface wrd_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] lower_limit;
	logic signed [31:0] upper_limit;
	logic [10:0]        panels;

	modport source (output valid, lower_limit, upper_limit, panels, input ready);
	modport sink (input valid, lower_limit, upper_limit, panels, output ready);
endinterface
`default_nettype wire

// ----- src/wrd_out_if.sv -----
// output channel: integral and overflow flag
// no dependencies
`default_nettype none
interface wrd_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] integral;
	logic               overflow;

	modport source (output valid, integral, overflow, input ready);
	modport sink (input valid, integral, overflow, output ready);
endinterface
`default_nettype wire

// ----- src/wrd_div.sv -----
// shared restoring divider, one quotient bit per cycle
// depends on wrd_pkg; numerator arrives left aligned
`default_nettype none
module wrd_div import wrd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire div_req_t         req,
	input  wire logic [DIV_W-1:0] num,
	input  wire logic [DIV_W-1:0] den,
	output logic                  busy,
	output logic                  done,
	output logic [DIV_W-1:0]      quo
);
	logic             busy_q, done_q;
	logic [IT_W-1:0]  cnt_q;
	logic [DIV_W-1:0] rem_q, nsh_q, quo_q, den_q;
	logic [DIV_W:0]   r2, rn;
	logic             ge;

	assign r2 = {rem_q, nsh_q[DIV_W-1]};
	assign ge = r2 >= {1'b0, den_q};
	assign rn = ge ? r2 - {1'b0, den_q} : r2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == IT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			nsh_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rn[DIV_W-1:0];
			nsh_q <= nsh_q << 1;
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

// ----- src/wrd_mul.sv -----
// shared 32 by 32 unsigned multiplier with registered product
// depends on wrd_pkg
`default_nettype none
module wrd_mul import wrd_pkg::*; (
	input  wire logic               clk,
	input  wire logic [MUL_W-1:0]   a,
	input  wire logic [MUL_W-1:0]   b,
	output logic [2*MUL_W-1:0]      p_s1
);
	always_ff @(posedge clk) begin
		p_s1 <= (2*MUL_W)'(a) * (2*MUL_W)'(b);
	end
endmodule
`default_nettype wire

// ----- src/weddle_rule_integrator_top.sv -----
// channel | dir | payload
// item    | in  | lower_limit, upper_limit (Q16.16), panels
// result  | out | integral (Q16.16, saturated), overflow
//
// one item at a time; ready only while idle with no result waiting
// samples go through the shared divider, which takes one quotient bit per cycle
// the next item is accepted only after the result transfer
// reset is asynchronous and clears control and the sequencer state
// depends on wrd_pkg, wrd_in_if, wrd_out_if, wrd_div, wrd_mul, weddle_rule_integrator_top_assert.svh
`default_nettype none
module weddle_rule_integrator_top import wrd_pkg::*; #(
	parameter int MAX_PANELS = 1024,
	parameter int FRAC_BITS  = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	wrd_in_if.sink   item,
	wrd_out_if.source result
);
	localparam int PC_W  = $clog2(MAX_PANELS + 1);
	localparam int N_W   = $clog2(6 * MAX_PANELS + 1);
	localparam int SW    = $clog2(6 * (6 * MAX_PANELS + 1) + 1) + FRAC_BITS + 1;
	localparam int B_W   = SW + 2;
	localparam int NCH   = (B_W + 31) / 32;
	localparam int BX_W  = NCH * 32;
	localparam int PR_W  = BX_W + 32;
	localparam int CH_W  = $clog2(NCH + 1);
	localparam int RN_W  = 2 * FRAC_BITS + 2;
	localparam int WF_W  = FRAC_BITS + 4;
	localparam logic [DIV_W-1:0] ONE_F   = DIV_W'(1) << FRAC_BITS;
	localparam logic [DIV_W-1:0] DEN_MAX = DIV_W'(1) << (2 * FRAC_BITS + 1);
	localparam logic [DIV_W-1:0] NUM_R   = DIV_W'(1) << (2 * FRAC_BITS);
	localparam logic [PR_W-1:0]  M_BOUND = PR_W'(64'd21474836485);

	typedef enum logic [3:0] {
		S_IDLE, S_HDIV, S_SQ, S_SQW, S_DEN, S_FDIV, S_ACC,
		S_PMUL, S_PWAIT, S_PADD, S_CHK, S_MDIV, S_FIN
	} state_t;

	state_t             state_q;
	logic [N_W-1:0]     n_q, idx_q;
	logic [2:0]         ph_q;
	logic signed [31:0] hi_q, h_q, x_q;
	logic [31:0]        hmag_q;
	logic [SW-1:0]      s_q;
	logic [FRAC_BITS:0] f_q;
	logic [BX_W-1:0]    b_q;
	logic [PR_W-1:0]    p_q;
	logic [CH_W-1:0]    ch_q;
	logic signed [31:0] res_q;
	logic               ovf_q, rvalid_q;
	div_req_t           dreq_q;
	logic [DIV_W-1:0]   dnum_q, dden_q;
	logic [MUL_W-1:0]   ma_q, mb_q;

	logic               div_busy, div_done;
	logic [DIV_W-1:0]   quo;
	logic [2*MUL_W-1:0] prod_s1;

	logic [PC_W-1:0]    p_c;
	logic [N_W-1:0]     n_c;
	logic signed [32:0] diff;
	logic [32:0]        dmag;
	logic [31:0]        xmag;
	logic [DIV_W-1:0]   den_c, rnum_c;
	logic [2:0]         w_c;
	logic [WF_W-1:0]    wf_c;
	logic [SW-1:0]      s_next;
	logic [PR_W-1:0]    m_c;
	logic [35:0]        mnum_c;
	logic [32:0]        mag_c;

	wrd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq_q),
		.num    (dnum_q),
		.den    (dden_q),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (quo)
	);

	wrd_mul u_mul (
		.clk  (clk),
		.a    (ma_q),
		.b    (mb_q),
		.p_s1 (prod_s1)
	);

	always_comb begin
		p_c    = (32'(item.panels) > 32'(MAX_PANELS)) ? PC_W'(MAX_PANELS)
			: PC_W'(item.panels);
		n_c    = (N_W'(p_c) << 2) + (N_W'(p_c) << 1);
		diff   = 33'(item.upper_limit) - 33'(item.lower_limit);
		dmag   = diff[32] ? 33'(-diff) : 33'(diff);
		xmag   = x_q[31] ? 32'(-x_q) : 32'(x_q);
		den_c  = ONE_F + (prod_s1 >> FRAC_BITS);
		rnum_c = NUM_R + (den_c >> 1);
		w_c    = (idx_q == '0 || idx_q == n_q) ? 3'd1 : wrd_weight(ph_q);
		wf_c   = WF_W'(f_q) * WF_W'(w_c);
		s_next = s_q + SW'(wf_c);
		m_c    = p_q >> FRAC_BITS;
		mnum_c = 36'(m_c) + 36'd5;
		mag_c  = quo[32:0];
	end

	assign item.ready      = (state_q == S_IDLE) && !rvalid_q;
	assign result.valid    = rvalid_q;
	assign result.integral = res_q;
	assign result.overflow = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rvalid_q <= 1'b0;
			dreq_q   <= '0;
			n_q      <= '0;
			idx_q    <= '0;
			ph_q     <= '0;
			h_q      <= '0;
			x_q      <= '0;
			s_q      <= '0;
		end else begin
			if (rvalid_q && result.ready)
				rvalid_q <= 1'b0;
			else if (state_q == S_FIN)
				rvalid_q <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (item.valid && item.ready) begin
						if (p_c == '0) begin
							res_q   <= '0;
							ovf_q   <= 1'b0;
							n_q     <= '0;
							idx_q   <= '0;
							h_q     <= '0;
							x_q     <= '0;
							s_q     <= '0;
							state_q <= S_FIN;
						end else begin
							hi_q    <= item.upper_limit;
							x_q     <= item.lower_limit;
							n_q     <= n_c;
							dnum_q  <= {dmag, (DIV_W-33)'(0)};
							dden_q  <= DIV_W'(n_c);
							dreq_q  <= '{start: 1'b1, iters: IT_W'(33)};
							state_q <= S_HDIV;
						end
					end
				end
				S_HDIV: begin
					dreq_q.start <= 1'b0;
					if (div_done) begin
						hmag_q  <= quo[31:0];
						h_q     <= (hi_q < x_q) ? -$signed(quo[31:0]) : $signed(quo[31:0]);
						idx_q   <= '0;
						ph_q    <= '0;
						s_q     <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					ma_q    <= xmag;
					mb_q    <= xmag;
					state_q <= S_SQW;
				end
				S_SQW: state_q <= S_DEN;
				S_DEN: begin
					if (den_c > DEN_MAX) begin
						f_q     <= '0;
						state_q <= S_ACC;
					end else begin
						dnum_q  <= rnum_c << (DIV_W - RN_W);
						dden_q  <= den_c;
						dreq_q  <= '{start: 1'b1, iters: IT_W'(RN_W)};
						state_q <= S_FDIV;
					end
				end
				S_FDIV: begin
					dreq_q.start <= 1'b0;
					if (div_done) begin
						f_q     <= quo[FRAC_BITS:0];
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					s_q <= s_next;
					if (idx_q == n_q) begin
						b_q     <= BX_W'(s_next) + (BX_W'(s_next) << 1);
						p_q     <= '0;
						ch_q    <= CH_W'(NCH);
						state_q <= S_PMUL;
					end else begin
						idx_q   <= idx_q + 1'b1;
						ph_q    <= (ph_q == 3'd5) ? 3'd0 : ph_q + 3'd1;
						x_q     <= (idx_q + 1'b1 == n_q) ? hi_q : x_q + h_q;
						state_q <= S_SQ;
					end
				end
				S_PMUL: begin
					ma_q    <= hmag_q;
					mb_q    <= b_q[BX_W-1 -: 32];
					b_q     <= b_q << 32;
					ch_q    <= ch_q - 1'b1;
					state_q <= S_PWAIT;
				end
				S_PWAIT: state_q <= S_PADD;
				S_PADD: begin
					p_q     <= (p_q << 32) + PR_W'(prod_s1);
					state_q <= (ch_q == '0) ? S_CHK : S_PMUL;
				end
				S_CHK: begin
					if (m_c >= M_BOUND) begin
						ovf_q   <= 1'b1;
						res_q   <= h_q[31] ? 32'sh80000000 : 32'sh7fffffff;
						state_q <= S_FIN;
					end else begin
						dnum_q  <= {mnum_c, (DIV_W-36)'(0)};
						dden_q  <= DIV_W'(10);
						dreq_q  <= '{start: 1'b1, iters: IT_W'(36)};
						state_q <= S_MDIV;
					end
				end
				S_MDIV: begin
					dreq_q.start <= 1'b0;
					if (div_done) begin
						if (h_q[31]) begin
							ovf_q <= 1'b0;
							res_q <= 32'(-$signed(mag_c));
						end else if (mag_c > 33'h07fffffff) begin
							ovf_q <= 1'b1;
							res_q <= 32'sh7fffffff;
						end else begin
							ovf_q <= 1'b0;
							res_q <= $signed(mag_c[31:0]);
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`include "weddle_rule_integrator_top_assert.svh"

	`WRD_ASSERT_IMP(a_ready_div_idle, item.ready, !div_busy)
	`WRD_ASSERT_IMP(a_done_in_wait, div_done,
		state_q == S_HDIV || state_q == S_FDIV || state_q == S_MDIV)
	`WRD_ASSERT_IMP(a_pos_sat, rvalid_q && ovf_q && !res_q[31], res_q == 32'sh7fffffff)
	`WRD_ASSERT_NXT(a_start_busy, dreq_q.start, div_busy)
endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// self-checking testbench for weddle_rule_integrator_top: directed limits, panel extremes, random
// items; predicts each integral in fixed point and compares every result transfer in order
// depends on wrd_pkg, wrd_in_if, wrd_out_if and the rtl under src
`default_nettype none
module tb;
	import wrd_pkg::*;

	localparam int FRAC = 16;
	localparam int PANEL_CAP = 1024;
	localparam int WATCHDOG_LIMIT = 1000000;

	typedef struct {
		logic signed [31:0] integral;
		logic               overflow;
	} weddle_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	wrd_in_if in_ch();
	wrd_out_if out_ch();

	weddle_result_t pending_integrals[$];
	bit no_idle = 1'b0;
	int errors = 0;
	int stall_cnt = 0;
	int quiet_cycles = 0;

	// predictor state, last item processed
	logic [63:0]        last_sum;
	logic [12:0]        last_index;
	logic signed [31:0] last_step;
	logic signed [31:0] last_point;

	weddle_rule_integrator_top #(.MAX_PANELS(PANEL_CAP), .FRAC_BITS(FRAC)) u_top (
		.clk(clk), .arst_n(arst_n), .item(in_ch), .result(out_ch)
	);

	always #5 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.lower_limit = '0;
		in_ch.upper_limit = '0;
		in_ch.panels = '0;
		out_ch.ready = 1'b0;
	end

	function automatic weddle_result_t weddle_integral(input logic signed [31:0] lo,
			input logic signed [31:0] hi, input logic [10:0] pc);
		weddle_result_t r;
		longint h, x, lo64, hi64;
		int unsigned p, n, i;
		longint unsigned a, den, f, s, w;
		logic [127:0] prod, m;
		logic [63:0] mag;
		bit neg, ovf;
		p = pc;
		if (p > PANEL_CAP)
			p = PANEL_CAP;
		r.integral = '0;
		r.overflow = 1'b0;
		if (p == 0) begin
			last_sum = '0; last_index = '0; last_step = '0; last_point = '0;
			return r;
		end
		lo64 = lo;
		hi64 = hi;
		n = 6 * p;
		h = (hi64 - lo64) / longint'(n);
		s = 0;
		x = 0;
		for (i = 0; i <= n; i++) begin
			x = (i == n) ? hi64 : lo64 + longint'(i) * h;
			a = (x < 0) ? longint'(-x) : x;
			den = (64'd1 << FRAC) + ((a * a) >> FRAC);
			f = ((64'd1 << (2 * FRAC)) + den / 2) / den;
			if (i == 0 || i == n)
				w = 1;
			else begin
				case (i % 6)
					0: w = 2;
					1: w = 5;
					2: w = 1;
					3: w = 6;
					4: w = 1;
					default: w = 5;
				endcase
			end
			s += w * f;
		end
		last_sum = s; last_index = 13'(n); last_step = 32'(h); last_point = 32'(x);
		neg = h < 0;
		a = neg ? longint'(-h) : h;
		prod = 128'(a) * 128'(64'(3 * s));
		m = prod >> FRAC;
		ovf = m > 128'h0000_0000_0000_0000_FFFF_FFFF_FFFF_FFFA;
		mag = ovf ? 64'd0 : 64'((m + 5) / 10);
		if (!neg) begin
			if (ovf || mag > 64'h7FFF_FFFF) begin
				ovf = 1'b1;
				r.integral = 32'h7FFF_FFFF;
			end else
				r.integral = mag[31:0];
		end else begin
			if (ovf || mag > 64'h8000_0000) begin
				ovf = 1'b1;
				r.integral = 32'h8000_0000;
			end else
				r.integral = -mag[31:0];
		end
		r.overflow = ovf;
		return r;
	endfunction

	task automatic send_item(input logic signed [31:0] lo, input logic signed [31:0] hi,
			input logic [10:0] pc);
		int gap;
		if (!no_idle && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 7);
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.lower_limit = lo;
		in_ch.upper_limit = hi;
		in_ch.panels = pc;
		forever begin
			@(posedge clk);
			if (in_ch.ready)
				break;
			@(negedge clk);
		end
		pending_integrals.push_back(weddle_integral(lo, hi, pc));
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_integrals.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// receiver stalls in random bursts, except while no_idle holds ready high
	always @(negedge clk) begin
		if (no_idle)
			out_ch.ready = 1'b1;
		else if (stall_cnt > 0) begin
			stall_cnt--;
			out_ch.ready = 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_cnt = $urandom_range(0, 6);
			out_ch.ready = 1'b0;
		end else
			out_ch.ready = 1'b1;
	end

	always @(posedge clk) begin
		weddle_result_t exp_r;
		if (out_ch.valid && out_ch.ready) begin
			if (pending_integrals.size() == 0) begin
				errors++;
				$display("%0t unexpected result integral=%h overflow=%b", $time,
					out_ch.integral, out_ch.overflow);
			end else begin
				exp_r = pending_integrals.pop_front();
				if (out_ch.integral !== exp_r.integral) begin
					errors++;
					$display("%0t integral expected %h actual %h", $time,
						exp_r.integral, out_ch.integral);
				end
				if (out_ch.overflow !== exp_r.overflow) begin
					errors++;
					$display("%0t overflow expected %b actual %b", $time,
						exp_r.overflow, out_ch.overflow);
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic test_extremes();
		send_item(32'sh0000_0000, 32'sh0001_0000, 11'd1);
		send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 11'd1);
		send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 11'd2);
		send_item(32'sh8000_0000, 32'sh8000_0000, 11'd1);
		send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 11'd3);
		send_item(32'shFFFF_0000, 32'sh0001_0000, 11'd1024);
		send_item(32'sh0000_0000, 32'sh0004_0000, 11'd512);
		send_item(32'shFFFC_0000, 32'sh0004_0000, 11'd255);
		send_item(32'sh5555_5555, 32'shAAAA_AAAA, 11'd127);
	endtask

	task automatic test_special_cases();
		send_item(32'sh0001_0000, 32'sh0003_0000, 11'd0);
		send_item(32'shFFFF_FFFF, 32'sh7FFF_FFFF, 11'd2047);
		send_item(32'sh0002_0000, 32'sh0002_0000, 11'd5);
		send_item(32'sh0003_0000, 32'shFFFD_0000, 11'd4);
		send_item(32'sh0000_0001, 32'sh0000_0002, 11'd7);
		send_item(32'shFFFF_FFFF, 32'sh0000_0000, 11'd1);
	endtask

	task automatic test_drain_pause();
		send_item(32'sh0000_0000, 32'sh0002_0000, 11'd2);
		wait_drained();
		send_item(32'shFFFE_0000, 32'sh0000_8000, 11'd3);
	endtask

	task automatic test_random(input int count);
		logic signed [31:0] lo, hi;
		logic [10:0] pc;
		int k;
		for (k = 0; k < count; k++) begin
			if (k >= count - 20)
				no_idle = 1'b1;
			if ($urandom_range(0, 3) == 0) begin
				lo = $urandom;
				hi = $urandom;
			end else begin
				lo = $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
				hi = $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
			end
			if ($urandom_range(0, 15) == 0)
				pc = 11'($urandom_range(0, 64));
			else
				pc = 11'($urandom_range(1, 12));
			send_item(lo, hi, pc);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_extremes();
		test_special_cases();
		test_drain_pause();
		test_random(83);
		wait_drained();
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_integrals.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire
